FILE: design/pic18_instruction_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef PIC18_INSTRUCTION_DECODER_DEFINES_SVH
`define PIC18_INSTRUCTION_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pic18id_pkg.sv
// Package for the PIC18 instruction decoder: pattern tables, format and
// status codes, result struct. No dependencies.
package pic18id_pkg;

  localparam int EntryCount   = 77;
  localparam int PatternCount = EntryCount - 1;
  localparam int IdW          = 7;

  localparam logic [IdW-1:0] INVALID_ID = IdW'(EntryCount - 1);

  localparam logic [3:0] FMT_NONE  = 4'd0;
  localparam logic [3:0] FMT_FDA   = 4'd1;
  localparam logic [3:0] FMT_MOVFF = 4'd2;
  localparam logic [3:0] FMT_FBA   = 4'd3;
  localparam logic [3:0] FMT_LIT   = 4'd4;
  localparam logic [3:0] FMT_SBR   = 4'd5;
  localparam logic [3:0] FMT_CALL  = 4'd6;
  localparam logic [3:0] FMT_LBR   = 4'd7;
  localparam logic [3:0] FMT_FA    = 4'd8;
  localparam logic [3:0] FMT_GOTO  = 4'd9;
  localparam logic [3:0] FMT_MOVLB = 4'd10;
  localparam logic [3:0] FMT_SBIT  = 4'd11;
  localparam logic [3:0] FMT_LFSR  = 4'd12;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_PREFIX  = 3'd4;

  localparam logic [3:0] SECOND_PREFIX = 4'hf;

  localparam logic [15:0] MUST_SET [0:EntryCount-1] = '{
    16'hf000, 16'hef00, 16'hee00, 16'hec00, 16'he700, 16'he600, 16'he500, 16'he400,
    16'he300, 16'he200, 16'he100, 16'he000, 16'hd800, 16'hd000, 16'hc000, 16'hb000,
    16'ha000, 16'h9000, 16'h8000, 16'h7000, 16'h6e00, 16'h6c00, 16'h6a00, 16'h6800,
    16'h6600, 16'h6400, 16'h6200, 16'h6000, 16'h5c00, 16'h5800, 16'h5400, 16'h5000,
    16'h4c00, 16'h4800, 16'h4400, 16'h4000, 16'h3c00, 16'h3800, 16'h3400, 16'h3000,
    16'h2c00, 16'h2800, 16'h2400, 16'h2000, 16'h1c00, 16'h1800, 16'h1400, 16'h1000,
    16'h0f00, 16'h0e00, 16'h0d00, 16'h0c00, 16'h0b00, 16'h0a00, 16'h0900, 16'h0800,
    16'h0400, 16'h0200, 16'h0100, 16'h00ff, 16'h0012, 16'h0010, 16'h000f, 16'h000e,
    16'h000d, 16'h000c, 16'h000b, 16'h000a, 16'h0009, 16'h0008, 16'h0007, 16'h0006,
    16'h0005, 16'h0004, 16'h0003, 16'h0000, 16'h0000
  };

  localparam logic [15:0] MAY_SET [0:EntryCount-1] = '{
    16'hffff, 16'hefff, 16'hee3f, 16'hedff, 16'he7ff, 16'he6ff, 16'he5ff, 16'he4ff,
    16'he3ff, 16'he2ff, 16'he1ff, 16'he0ff, 16'hdfff, 16'hd7ff, 16'hcfff, 16'hbfff,
    16'hafff, 16'h9fff, 16'h8fff, 16'h7fff, 16'h6fff, 16'h6dff, 16'h6bff, 16'h69ff,
    16'h67ff, 16'h65ff, 16'h63ff, 16'h61ff, 16'h5fff, 16'h5bff, 16'h57ff, 16'h53ff,
    16'h4fff, 16'h4bff, 16'h47ff, 16'h43ff, 16'h3fff, 16'h3bff, 16'h37ff, 16'h33ff,
    16'h2fff, 16'h2bff, 16'h27ff, 16'h23ff, 16'h1fff, 16'h1bff, 16'h17ff, 16'h13ff,
    16'h0fff, 16'h0eff, 16'h0dff, 16'h0cff, 16'h0bff, 16'h0aff, 16'h09ff, 16'h08ff,
    16'h07ff, 16'h03ff, 16'h010f, 16'h00ff, 16'h0013, 16'h0011, 16'h000f, 16'h000e,
    16'h000d, 16'h000c, 16'h000b, 16'h000a, 16'h0009, 16'h0008, 16'h0007, 16'h0006,
    16'h0005, 16'h0004, 16'h0003, 16'h0000, 16'hffff
  };

  localparam logic [3:0] ENTRY_FORMAT [0:EntryCount-1] = '{
    FMT_NONE, FMT_GOTO, FMT_LFSR, FMT_CALL,
    FMT_SBR, FMT_SBR, FMT_SBR, FMT_SBR, FMT_SBR, FMT_SBR, FMT_SBR, FMT_SBR,
    FMT_LBR, FMT_LBR, FMT_MOVFF,
    FMT_FBA, FMT_FBA, FMT_FBA, FMT_FBA, FMT_FBA,
    FMT_FA, FMT_FA, FMT_FA, FMT_FA, FMT_FA, FMT_FA, FMT_FA, FMT_FA,
    FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA,
    FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA,
    FMT_FDA, FMT_FDA, FMT_FDA, FMT_FDA,
    FMT_LIT, FMT_LIT, FMT_LIT, FMT_LIT, FMT_LIT, FMT_LIT, FMT_LIT, FMT_LIT,
    FMT_FDA, FMT_FA, FMT_MOVLB, FMT_NONE, FMT_SBIT, FMT_SBIT,
    FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE,
    FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE, FMT_NONE,
    FMT_NONE
  };

  typedef struct packed {
    logic [2:0]     status;
    logic [IdW-1:0] mnemonic_id;
    logic [3:0]     arg_format;
    logic [2:0]     length_bytes;
    logic [20:0]    main_value;
    logic           dest_bit;
    logic           access_bit;
    logic [2:0]     bit_position;
    logic [1:0]     fsr_select;
    logic [11:0]    second_value;
  } result_t;

endpackage

FILE: design/pic18id_operands.sv
// Operand extraction for the PIC18 decoder: turns a table index and the
// instruction words into status, length and operand fields. Uses pic18id_pkg.
module pic18id_operands (
  input  logic [pic18id_pkg::IdW-1:0] id,
  input  logic [15:0]                 first_word,
  input  logic [15:0]                 second_word,
  input  logic [1:0]                  words,
  output pic18id_pkg::result_t        res
);

  logic [3:0] fmt;
  logic       two_word;

  always_comb begin
    res = '0;
    res.mnemonic_id = pic18id_pkg::INVALID_ID;
    fmt = pic18id_pkg::ENTRY_FORMAT[id];
    two_word = (fmt == pic18id_pkg::FMT_CALL) || (fmt == pic18id_pkg::FMT_GOTO) ||
               (fmt == pic18id_pkg::FMT_MOVFF) || (fmt == pic18id_pkg::FMT_LFSR);
    if (words == 2'd0) begin
      res.status = pic18id_pkg::ST_SHORT;
    end else if (id == pic18id_pkg::INVALID_ID) begin
      res.status       = pic18id_pkg::ST_INVALID;
      res.length_bytes = 3'd2;
    end else begin
      res.mnemonic_id = id;
      res.arg_format  = fmt;
      if (two_word && words == 2'd1) begin
        res.status       = pic18id_pkg::ST_MISSING;
        res.length_bytes = 3'd2;
      end else if (two_word && second_word[15:12] != pic18id_pkg::SECOND_PREFIX) begin
        res.status       = pic18id_pkg::ST_PREFIX;
        res.length_bytes = 3'd4;
      end else begin
        res.status       = pic18id_pkg::ST_OK;
        res.length_bytes = two_word ? 3'd4 : 3'd2;
        unique case (fmt)
          pic18id_pkg::FMT_SBR, pic18id_pkg::FMT_LIT: begin
            res.main_value = {13'd0, first_word[7:0]};
          end
          pic18id_pkg::FMT_FDA: begin
            res.main_value = {13'd0, first_word[7:0]};
            res.dest_bit   = first_word[9];
            res.access_bit = first_word[8];
          end
          pic18id_pkg::FMT_FA: begin
            res.main_value = {13'd0, first_word[7:0]};
            res.access_bit = first_word[8];
          end
          pic18id_pkg::FMT_FBA: begin
            res.main_value   = {13'd0, first_word[7:0]};
            res.bit_position = first_word[11:9];
            res.access_bit   = first_word[8];
          end
          pic18id_pkg::FMT_LBR: begin
            res.main_value = {10'd0, first_word[10:0]};
          end
          pic18id_pkg::FMT_CALL: begin
            res.main_value = {1'b0, second_word[11:0], first_word[7:0]};
            res.dest_bit   = first_word[8];
          end
          pic18id_pkg::FMT_GOTO: begin
            // word address doubled into a byte address
            res.main_value = {second_word[11:0], first_word[7:0], 1'b0};
          end
          pic18id_pkg::FMT_MOVFF: begin
            res.main_value   = {9'd0, first_word[11:0]};
            res.second_value = second_word[11:0];
          end
          pic18id_pkg::FMT_MOVLB: begin
            res.main_value = {17'd0, first_word[3:0]};
          end
          pic18id_pkg::FMT_SBIT: begin
            res.dest_bit = first_word[0];
          end
          pic18id_pkg::FMT_LFSR: begin
            res.fsr_select   = first_word[5:4];
            res.second_value = {first_word[3:0], second_word[7:0]};
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: design/pic18_instruction_decoder.sv
// PIC18 instruction decoder, usage notes:
// Input channel in_*: first_word, second_word and words_present (0..2,
// 3 counts as 2) move on a transfer when in_valid is high and in_stall low.
// Result channel out_*: one result per input item, taken when out_valid is
// high and out_stall low.
// The pattern compare result is registered in stage 1, the priority encode
// result in stage 2 and the operand extract result in the output register.
// Throughput: one item per cycle while out_stall is low; a stage holds one item.
// A stage advances when it is empty or the stage after it advances, so
// bubbles collapse and in_stall rises only when every stage is full and
// out_stall is high. A stalled result holds its value.
// Reset (rst_n low at a clock edge) empties all stages; the tables are
// constant logic and need no initialization.
// Depends on pic18id_pkg, pic18id_operands and the assertion macro header.
`include "pic18_instruction_decoder_defines.svh"

module pic18_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_first_word,
  input  logic [15:0] in_second_word,
  input  logic [1:0]  in_words_present,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [6:0]  out_mnemonic_id,
  output logic [3:0]  out_arg_format,
  output logic [2:0]  out_length_bytes,
  output logic [20:0] out_main_value,
  output logic        out_dest_bit,
  output logic        out_access_bit,
  output logic [2:0]  out_bit_position,
  output logic [1:0]  out_fsr_select,
  output logic [11:0] out_second_value
);

  localparam int NPat = pic18id_pkg::PatternCount;

  // stage 1: pattern match vector
  logic            s1_v_r, s1_v_nxt;
  logic [NPat-1:0] s1_match_r, s1_match_nxt;
  logic [15:0]     s1_w1_r, s1_w2_r;
  logic [1:0]      s1_words_r, s1_words_nxt;

  // stage 2: winning table index
  logic                         s2_v_r, s2_v_nxt;
  logic [pic18id_pkg::IdW-1:0]  s2_id_r, s2_id_nxt;
  logic [15:0]                  s2_w1_r, s2_w2_r;
  logic [1:0]                   s2_words_r;

  // stage 3: output register
  logic                 out_v_r, out_v_nxt;
  pic18id_pkg::result_t out_res_r, out_res_nxt;

  logic out_ready, s2_ready, s1_ready;

  assign out_ready = !out_v_r || !out_stall;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_stall  = !s1_ready;

  assign s1_v_nxt  = s1_ready ? in_valid : s1_v_r;
  assign s2_v_nxt  = s2_ready ? s1_v_r : s2_v_r;
  assign out_v_nxt = out_ready ? s2_v_r : out_v_r;

  assign s1_words_nxt = (in_words_present == 2'd3) ? 2'd2 : in_words_present;

  always_comb begin
    for (int k = 0; k < NPat; k++) begin
      s1_match_nxt[k] =
        ((pic18id_pkg::MUST_SET[k] & in_first_word) == pic18id_pkg::MUST_SET[k]) &&
        ((pic18id_pkg::MAY_SET[k] | in_first_word) == pic18id_pkg::MAY_SET[k]);
    end
  end

  // first match in table order wins; no match falls to the catch-all entry
  always_comb begin
    s2_id_nxt = pic18id_pkg::INVALID_ID;
    for (int k = NPat - 1; k >= 0; k--) begin
      if (s1_match_r[k]) begin
        s2_id_nxt = pic18id_pkg::IdW'(k);
      end
    end
  end

  pic18id_operands u_operands (
    .id          (s2_id_r),
    .first_word  (s2_w1_r),
    .second_word (s2_w2_r),
    .words       (s2_words_r),
    .res         (out_res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_match_r <= s1_match_nxt;
      s1_w1_r    <= in_first_word;
      s1_w2_r    <= in_second_word;
      s1_words_r <= s1_words_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_id_r    <= s2_id_nxt;
      s2_w1_r    <= s1_w1_r;
      s2_w2_r    <= s1_w2_r;
      s2_words_r <= s1_words_r;
    end
    if (out_ready && s2_v_r) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_status       = out_res_r.status;
  assign out_mnemonic_id  = out_res_r.mnemonic_id;
  assign out_arg_format   = out_res_r.arg_format;
  assign out_length_bytes = out_res_r.length_bytes;
  assign out_main_value   = out_res_r.main_value;
  assign out_dest_bit     = out_res_r.dest_bit;
  assign out_access_bit   = out_res_r.access_bit;
  assign out_bit_position = out_res_r.bit_position;
  assign out_fsr_select   = out_res_r.fsr_select;
  assign out_second_value = out_res_r.second_value;

  `PID_ASSERT_NEXT(a_s1_hold, s1_v_r && !s2_ready, s1_v_r, "stage 1 item lost under stall")
  `PID_ASSERT_NEXT(a_s2_hold, s2_v_r && !out_ready, s2_v_r, "stage 2 item lost under stall")
  `PID_ASSERT_NOW(a_short, out_v_r && out_res_r.status == pic18id_pkg::ST_SHORT, out_res_r.length_bytes == 3'd0 && out_res_r.mnemonic_id == pic18id_pkg::INVALID_ID, "short item carries a length or index")
  `PID_ASSERT_NOW(a_len4, out_v_r && out_res_r.length_bytes == 3'd4, out_res_r.status == pic18id_pkg::ST_OK || out_res_r.status == pic18id_pkg::ST_PREFIX, "four-byte length with wrong status")

endmodule
